/* design/rcs_pkg.sv */
// Shared types, constants and lookup functions for the three-rotor cipher stepper.
`timescale 1ns / 1ps

package rcs_pkg;

    localparam int LETTERS  = 4;
    localparam int LETTER_W = 2;
    localparam int TABLE_W  = LETTERS * LETTER_W;
    localparam int NOTCH_W  = 2 * LETTER_W;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;

    // Register indexes (byte address is 4 * index)
    localparam logic [IDX_W-1:0] REG_FAST   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MEDIUM = 3'd1;
    localparam logic [IDX_W-1:0] REG_SLOW   = 3'd2;
    localparam logic [IDX_W-1:0] REG_REFL   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PLUG   = 3'd4;
    localparam logic [IDX_W-1:0] REG_ENTRY  = 3'd5;
    localparam logic [IDX_W-1:0] REG_NOTCH  = 3'd6;

    localparam logic [TABLE_W-1:0] FAST_RESET   = 8'd30;
    localparam logic [TABLE_W-1:0] MEDIUM_RESET = 8'd45;
    localparam logic [TABLE_W-1:0] SLOW_RESET   = 8'd156;
    localparam logic [TABLE_W-1:0] REFL_RESET   = 8'd27;
    localparam logic [TABLE_W-1:0] PLUG_RESET   = 8'd228;
    localparam logic [TABLE_W-1:0] ENTRY_RESET  = 8'd228;
    localparam logic [NOTCH_W-1:0] NOTCH_RESET  = 4'd13;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [TABLE_W-1:0]  table_t;

    typedef struct packed {
        table_t                fast;
        table_t                middle;
        table_t                slow;
        table_t                refl;
        table_t                plug;
        table_t                entry;
        logic [NOTCH_W-1:0]    notch;
    } cfg_t;

    typedef struct packed {
        letter_t fast;
        letter_t middle;
        letter_t slow;
    } pos_t;

    // Forward lookup: entry i sits in bits 2i+1..2i
    function automatic letter_t fwd(input table_t tbl, input letter_t i);
        return tbl[i*LETTER_W +: LETTER_W];
    endfunction

    // Inverse lookup: highest index whose entry matches, zero when none does
    function automatic letter_t inv(input table_t tbl, input letter_t x);
        letter_t res;
        res = '0;
        for (int i = 0; i < LETTERS; i++) begin
            if (tbl[i*LETTER_W +: LETTER_W] == x) begin
                res = letter_t'(i);
            end
        end
        return res;
    endfunction

endpackage

/* design/rcs_regs.sv */
// APB configuration register file holding the rotor wirings and notches.
`timescale 1ns / 1ps

module rcs_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcs_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcs_pkg::DATA_W-1:0]   pwdata,
    output logic [rcs_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output rcs_pkg::cfg_t                cfg
);

    rcs_pkg::cfg_t                  cfg_reg;
    logic [rcs_pkg::IDX_W-1:0]      idx;
    logic                           wr_en;

    assign idx    = paddr[rcs_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.fast   <= rcs_pkg::FAST_RESET;
            cfg_reg.middle <= rcs_pkg::MEDIUM_RESET;
            cfg_reg.slow   <= rcs_pkg::SLOW_RESET;
            cfg_reg.refl   <= rcs_pkg::REFL_RESET;
            cfg_reg.plug   <= rcs_pkg::PLUG_RESET;
            cfg_reg.entry  <= rcs_pkg::ENTRY_RESET;
            cfg_reg.notch  <= rcs_pkg::NOTCH_RESET;
        end
        else if (wr_en) begin
            case (idx)
                rcs_pkg::REG_FAST:   cfg_reg.fast   <= pwdata[rcs_pkg::TABLE_W-1:0];
                rcs_pkg::REG_MEDIUM: cfg_reg.middle <= pwdata[rcs_pkg::TABLE_W-1:0];
                rcs_pkg::REG_SLOW:   cfg_reg.slow   <= pwdata[rcs_pkg::TABLE_W-1:0];
                rcs_pkg::REG_REFL:   cfg_reg.refl   <= pwdata[rcs_pkg::TABLE_W-1:0];
                rcs_pkg::REG_PLUG:   cfg_reg.plug   <= pwdata[rcs_pkg::TABLE_W-1:0];
                rcs_pkg::REG_ENTRY:  cfg_reg.entry  <= pwdata[rcs_pkg::TABLE_W-1:0];
                rcs_pkg::REG_NOTCH:  cfg_reg.notch  <= pwdata[rcs_pkg::NOTCH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            rcs_pkg::REG_FAST:   prdata = rcs_pkg::DATA_W'(cfg_reg.fast);
            rcs_pkg::REG_MEDIUM: prdata = rcs_pkg::DATA_W'(cfg_reg.middle);
            rcs_pkg::REG_SLOW:   prdata = rcs_pkg::DATA_W'(cfg_reg.slow);
            rcs_pkg::REG_REFL:   prdata = rcs_pkg::DATA_W'(cfg_reg.refl);
            rcs_pkg::REG_PLUG:   prdata = rcs_pkg::DATA_W'(cfg_reg.plug);
            rcs_pkg::REG_ENTRY:  prdata = rcs_pkg::DATA_W'(cfg_reg.entry);
            rcs_pkg::REG_NOTCH:  prdata = rcs_pkg::DATA_W'(cfg_reg.notch);
            default:             prdata = '0;
        endcase
    end

endmodule

/* design/rcs_stepper.sv */
// Rotor position state and the notch-driven stepping rule.
`timescale 1ns / 1ps

module rcs_stepper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [rcs_pkg::NOTCH_W-1:0]   notch,
    output rcs_pkg::pos_t                 pos_next
);

    rcs_pkg::pos_t     pos_reg;
    rcs_pkg::letter_t  fast_notch;
    rcs_pkg::letter_t  medium_notch;
    logic              fast_hit;
    logic              medium_hit;

    assign fast_notch   = notch[rcs_pkg::LETTER_W-1:0];
    assign medium_notch = notch[rcs_pkg::NOTCH_W-1:rcs_pkg::LETTER_W];

    // Fast always advances; the others carry when one past their notch
    always_comb begin
        pos_next.fast   = pos_reg.fast + 1'b1;
        fast_hit        = (pos_next.fast == rcs_pkg::letter_t'(fast_notch + 1'b1));
        pos_next.middle = pos_reg.middle + rcs_pkg::letter_t'(fast_hit);
        medium_hit      = (pos_next.middle == rcs_pkg::letter_t'(medium_notch + 1'b1));
        pos_next.slow   = pos_reg.slow + rcs_pkg::letter_t'(fast_hit && medium_hit);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg <= '0;
        end
        else if (step_en) begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* design/rcs_path.sv */
// Combinational signal path: plugboard, rotors, reflector and the way back.
`timescale 1ns / 1ps

module rcs_path (
    input  rcs_pkg::cfg_t     cfg,
    input  rcs_pkg::pos_t     pos,
    input  rcs_pkg::letter_t  letter,
    output rcs_pkg::letter_t  cipher
);

    rcs_pkg::letter_t x_plug, x_entry, x_fast, x_medium, x_slow, x_refl;
    rcs_pkg::letter_t r_slow, r_medium, r_fast, r_entry;

    // Two-bit arithmetic wraps modulo the alphabet size
    always_comb begin
        x_plug   = rcs_pkg::fwd(cfg.plug, letter);
        x_entry  = rcs_pkg::fwd(cfg.entry, x_plug);
        x_fast   = rcs_pkg::fwd(cfg.fast, rcs_pkg::letter_t'(pos.fast + x_entry));
        x_medium = rcs_pkg::fwd(cfg.middle,
                       rcs_pkg::letter_t'(pos.middle + x_fast - pos.fast));
        x_slow   = rcs_pkg::fwd(cfg.slow,
                       rcs_pkg::letter_t'(pos.slow + x_medium - pos.middle));
        x_refl   = rcs_pkg::fwd(cfg.refl, rcs_pkg::letter_t'(x_slow - pos.slow));

        r_slow   = rcs_pkg::inv(cfg.slow, rcs_pkg::letter_t'(pos.slow + x_refl));
        r_medium = rcs_pkg::inv(cfg.middle,
                       rcs_pkg::letter_t'(pos.middle + r_slow - pos.slow));
        r_fast   = rcs_pkg::inv(cfg.fast,
                       rcs_pkg::letter_t'(pos.fast + r_medium - pos.middle));
        r_entry  = rcs_pkg::inv(cfg.entry, rcs_pkg::letter_t'(r_fast - pos.fast));
        cipher   = rcs_pkg::fwd(cfg.plug, r_entry);
    end

endmodule

/* design/three_rotor_cipher_stepper.sv */
// Top level of the three-rotor cipher stepper: register file, stepping and pipeline.
`timescale 1ns / 1ps
// Usage
//   Letters enter on the letter channel (plain_letter, letter_valid/letter_ready).
//   Each accepted transfer steps the rotors (fast always, medium and slow by
//   their notches) and enciphers the letter with the new positions. One result
//   transfer per letter leaves on the result channel (cipher_letter plus the
//   three positions after stepping, result_valid/result_ready).
//   Rotor wirings, plugboard, entry rotor, reflector and notches sit in an APB
//   register file at byte address 4*index; write them only while no letter is
//   in flight.
// Pipeline and throughput
//   A letter is captured into the input stage at acceptance with the stepped
//   positions; the cipher path runs from that stage into the result register.
//   The result is valid once loaded into the result register and then waits
//   for result_ready; one letter per cycle is taken while the receiver keeps up.
// Reset and stall
//   Reset clears both stages and puts the rotors at position zero and every
//   register at its default. When the receiver holds result_ready low, the
//   result register holds; the input stage still takes one more letter and
//   then letter_ready drops until the result drains.
module three_rotor_cipher_stepper (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcs_pkg::ADDR_W-1:0]    paddr,
    input  logic [rcs_pkg::DATA_W-1:0]    pwdata,
    output logic [rcs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // letter channel
    input  logic                          letter_valid,
    output logic                          letter_ready,
    input  logic [rcs_pkg::LETTER_W-1:0]  plain_letter,
    // result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [rcs_pkg::LETTER_W-1:0]  cipher_letter,
    output logic [rcs_pkg::LETTER_W-1:0]  fast_position,
    output logic [rcs_pkg::LETTER_W-1:0]  medium_position,
    output logic [rcs_pkg::LETTER_W-1:0]  slow_position
);

    rcs_pkg::cfg_t     cfg;
    rcs_pkg::pos_t     pos_next;
    rcs_pkg::letter_t  cipher;

    logic              accept;
    logic              out_advance;
    logic              stage_advance;

    // input stage
    logic              stage_valid_reg;
    rcs_pkg::letter_t  stage_letter_reg;
    rcs_pkg::pos_t     stage_pos_reg;

    // result register
    logic              res_valid_reg;
    rcs_pkg::letter_t  res_cipher_reg;
    rcs_pkg::pos_t     res_pos_reg;

    // Result register frees when empty or being taken; the input stage
    // frees when empty or moving into the result register
    assign out_advance   = !res_valid_reg || result_ready;
    assign stage_advance = !stage_valid_reg || out_advance;
    assign letter_ready  = stage_advance;
    assign accept        = letter_valid && letter_ready;

    rcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Rotors step exactly once per accepted letter
    rcs_stepper u_stepper (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (accept),
        .notch    (cfg.notch),
        .pos_next (pos_next)
    );

    rcs_path u_path (
        .cfg    (cfg),
        .pos    (stage_pos_reg),
        .letter (stage_letter_reg),
        .cipher (cipher)
    );

    // Input stage: capture letter and stepped positions on a transfer
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end
        else if (stage_advance) begin
            stage_valid_reg <= letter_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            stage_letter_reg <= plain_letter;
            stage_pos_reg    <= pos_next;
        end
    end

    // Result register: load from the cipher path, hold while stalled
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (out_advance) begin
            res_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (out_advance && stage_valid_reg) begin
            res_cipher_reg <= cipher;
            res_pos_reg    <= stage_pos_reg;
        end
    end

    assign result_valid    = res_valid_reg;
    assign cipher_letter   = res_cipher_reg;
    assign fast_position   = res_pos_reg.fast;
    assign medium_position = res_pos_reg.middle;
    assign slow_position   = res_pos_reg.slow;

endmodule

/* design/rcs_checker.sv */
// Port-level checks for the three-rotor cipher stepper, bound to the top level.
`timescale 1ns / 1ps

module rcs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pready,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic [rcs_pkg::LETTER_W-1:0]  cipher_letter,
    input  logic [rcs_pkg::LETTER_W-1:0]  fast_position,
    input  logic [rcs_pkg::LETTER_W-1:0]  medium_position,
    input  logic [rcs_pkg::LETTER_W-1:0]  slow_position
);

    logic              seen_reg;
    rcs_pkg::letter_t  prev_fast_reg;
    rcs_pkg::letter_t  prev_medium_reg;
    rcs_pkg::letter_t  prev_slow_reg;
    logic              res_xfer;

    assign res_xfer = result_valid && result_ready;

    // Remember the positions of the last result transfer
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seen_reg        <= 1'b0;
            prev_fast_reg   <= '0;
            prev_medium_reg <= '0;
            prev_slow_reg   <= '0;
        end
        else if (res_xfer) begin
            seen_reg        <= 1'b1;
            prev_fast_reg   <= fast_position;
            prev_medium_reg <= medium_position;
            prev_slow_reg   <= slow_position;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(cipher_letter)
            && $stable(fast_position))
        else $error("result changed while stalled");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_fast_advance: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && seen_reg |->
            fast_position == rcs_pkg::letter_t'(prev_fast_reg + 1'b1))
        else $error("fast rotor did not advance by one");

    a_slow_carry: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && seen_reg && slow_position != prev_slow_reg |->
            medium_position != prev_medium_reg)
        else $error("slow rotor stepped without the medium rotor");

endmodule

bind three_rotor_cipher_stepper rcs_checker u_rcs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pready          (pready),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .cipher_letter   (cipher_letter),
    .fast_position   (fast_position),
    .medium_position (medium_position),
    .slow_position   (slow_position)
);
